// ===== src/kmpm_pkg.sv =====
// kmpm_pkg: shared types and constants for the KMP stream matcher.
// Used by kmp_stream_matcher, kmp_stream_matcher_chk and kmp_stream_matcher_tb. Depends on nothing.
`default_nettype none

package kmpm_pkg;

   // Pattern store depth and derived widths
   localparam int MAX_PATTERN = 256;
   localparam int ADDR_W      = $clog2(MAX_PATTERN);
   localparam int LEN_W       = 9;   // fixed width of match_len, holds 0..MAX_PATTERN
   localparam int SYM_W       = 8;

   typedef enum logic [1:0] {
      OP_CLEAR   = 2'd0,
      OP_APPEND  = 2'd1,
      OP_TEXT    = 2'd2,
      OP_RESTART = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_CMP,
      S_RESP
   } state_type;

   typedef struct packed {
      opcode_type        opcode;
      logic [SYM_W-1:0]  symbol;
   } req_type;

   typedef struct packed {
      logic [LEN_W-1:0]  match_len;
      logic              full_match;
      status_type        status;
   } rsp_type;

endpackage

`default_nettype wire

// ===== src/kmpm_ram.sv =====
// kmpm_ram: simple dual-port RAM, one write port and one registered read port.
// Generic; no package dependency.
`default_nettype none

module kmpm_ram #(
   parameter int  WIDTH = 8,
   parameter int  DEPTH = 256,
   localparam int AW    = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// ===== src/kmp_stream_matcher.sv =====
// kmp_stream_matcher: top level of the Knuth-Morris-Pratt byte stream matcher.
// Depends on kmpm_pkg and kmpm_ram (pattern store and failure table).
//
//   Channel   Direction   Handshake            Payload
//   req_*     in          req_valid/req_stall  req_type: opcode, symbol
//   rsp_*     out         rsp_valid/rsp_stall  rsp_type: match_len, full_match, status
//
// Clear, restart, first or dropped append, text with empty pattern: S_IDLE, then S_RESP.
// Other appends and text bytes: S_IDLE, then 1 + W probes, then S_RESP; W = failure-link steps taken
//   for that byte; each probe is a table read step (S_READ) and a compare step (S_CMP) on the
//   shared comparator. W averages at most about one per byte over a stream.
// Reset (synchronous, active high) empties the pattern; tables need no clearing.
// A request is taken while the previous response still waits on rsp_stall; the
// next response then holds in its final step until the output register frees.
`default_nettype none

module kmp_stream_matcher (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire kmpm_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output kmpm_pkg::rsp_type      rsp_data
);

   import kmpm_pkg::*;

   state_type         state_ff, state_in;
   opcode_type        op_ff, op_in;
   logic [SYM_W-1:0]  sym_ff, sym_in;
   logic [LEN_W-1:0]  j_ff, j_in;
   logic [LEN_W-1:0]  plen_ff, plen_in;
   logic [LEN_W-1:0]  bpref_ff, bpref_in;
   logic [LEN_W-1:0]  tpref_ff, tpref_in;
   logic [LEN_W-1:0]  last_fail_ff, last_fail_in;
   rsp_type           res_ff, res_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   // table ports
   logic              ps_we;
   logic [ADDR_W-1:0] ps_waddr;
   logic [SYM_W-1:0]  ps_wdata;
   logic [SYM_W-1:0]  ps_rd;
   logic              ft_we;
   logic [ADDR_W-1:0] ft_waddr;
   logic [LEN_W-1:0]  ft_wdata;
   logic [LEN_W-1:0]  ft_rd;
   logic [LEN_W-1:0]  jm1;

   logic              req_fire;
   logic              rsp_free;
   logic              plen_full;
   logic              plen_zero;
   logic              hit;
   logic              walk_back;
   logic [LEN_W-1:0]  j_adv;

   assign req_stall = (state_ff != S_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign plen_full = (plen_ff >= LEN_W'(MAX_PATTERN));
   assign plen_zero = (plen_ff == '0);

   // shared compare unit: one probe of the failure walk
   assign jm1       = j_ff - LEN_W'(1);
   assign hit       = (ps_rd == sym_ff);
   assign walk_back = (j_ff != '0) && !hit;
   assign j_adv     = j_ff + LEN_W'(hit);

   kmpm_ram #(.WIDTH(SYM_W), .DEPTH(MAX_PATTERN)) u_pattern (
      .clock   (clock),
      .wr_en   (ps_we),
      .wr_addr (ps_waddr),
      .wr_data (ps_wdata),
      .rd_addr (j_ff[ADDR_W-1:0]),
      .rd_data (ps_rd)
   );

   kmpm_ram #(.WIDTH(LEN_W), .DEPTH(MAX_PATTERN)) u_failure (
      .clock   (clock),
      .wr_en   (ft_we),
      .wr_addr (ft_waddr),
      .wr_data (ft_wdata),
      .rd_addr (jm1[ADDR_W-1:0]),
      .rd_data (ft_rd)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if ((req_data.opcode == OP_APPEND && !plen_zero && !plen_full) ||
                   (req_data.opcode == OP_TEXT && !plen_zero)) begin
                  state_in = S_READ;
               end else begin
                  state_in = S_RESP;
               end
            end
         end
         S_READ: state_in = S_CMP;
         S_CMP: begin
            if (walk_back) begin
               state_in = S_READ;
            end else begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and table control
   always_comb begin
      op_in        = op_ff;
      sym_in       = sym_ff;
      j_in         = j_ff;
      plen_in      = plen_ff;
      bpref_in     = bpref_ff;
      tpref_in     = tpref_ff;
      last_fail_in = last_fail_ff;
      res_in       = res_ff;
      ps_we        = 1'b0;
      ps_waddr     = plen_ff[ADDR_W-1:0];
      ps_wdata     = req_data.symbol;
      ft_we        = 1'b0;
      ft_waddr     = plen_ff[ADDR_W-1:0];
      ft_wdata     = j_adv;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in  = req_data.opcode;
               sym_in = req_data.symbol;
               res_in = '{match_len: '0, full_match: 1'b0, status: ST_OK};
               case (req_data.opcode)
                  OP_CLEAR: begin
                     plen_in  = '0;
                     bpref_in = '0;
                     tpref_in = '0;
                  end
                  OP_APPEND: begin
                     if (plen_full) begin
                        res_in.status = ST_FULL;
                     end else begin
                        ps_we = 1'b1;
                        if (plen_zero) begin
                           // first byte: failure entry is zero
                           ft_we        = 1'b1;
                           ft_wdata     = '0;
                           bpref_in     = '0;
                           last_fail_in = '0;
                           plen_in      = LEN_W'(1);
                        end else begin
                           j_in = bpref_ff;
                        end
                     end
                  end
                  OP_TEXT: begin
                     if (plen_zero) begin
                        res_in.status = ST_EMPTY;
                     end else begin
                        j_in = tpref_ff;
                     end
                  end
                  OP_RESTART: tpref_in = '0;
                  default: tpref_in = tpref_ff;
               endcase
            end
         end
         S_CMP: begin
            if (walk_back) begin
               j_in = ft_rd;
            end else if (op_ff == OP_APPEND) begin
               ft_we        = 1'b1;
               bpref_in     = j_adv;
               last_fail_in = j_adv;
               plen_in      = plen_ff + LEN_W'(1);
            end else begin
               res_in.match_len = j_adv;
               if (j_adv >= plen_ff) begin
                  // whole pattern matched: fall back for overlaps
                  res_in.full_match = 1'b1;
                  tpref_in          = last_fail_ff;
               end else begin
                  tpref_in = j_adv;
               end
            end
         end
         S_RESP: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
            end
         end
         default: j_in = j_ff;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         plen_ff      <= '0;
         bpref_ff     <= '0;
         tpref_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         plen_ff      <= plen_in;
         bpref_ff     <= bpref_in;
         tpref_ff     <= tpref_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      sym_ff       <= sym_in;
      j_ff         <= j_in;
      last_fail_ff <= last_fail_in;
      res_ff       <= res_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // a probe never reaches past the stored pattern
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ || state_ff == S_CMP) |-> (j_ff < plen_ff))
      else $error("walk index beyond pattern length");

   // matched text prefix stays strictly inside the pattern
   assert property (@(posedge clock) disable iff (reset)
      (tpref_ff < plen_ff) || (plen_ff == '0 && tpref_ff == '0))
      else $error("text prefix out of range");

   // builder prefix stays strictly inside the pattern
   assert property (@(posedge clock) disable iff (reset)
      (bpref_ff < plen_ff) || (plen_ff == '0 && bpref_ff == '0))
      else $error("builder prefix out of range");

   // a full match reports the whole pattern length
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESP && res_ff.full_match) |-> (res_ff.match_len == plen_ff))
      else $error("full match with short length");

   // a finished result lands in the output register
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESP && rsp_free) |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("result not delivered");

endmodule

`default_nettype wire

// ===== tb/kmp_stream_matcher_chk.sv =====
// kmp_stream_matcher_chk: watches both channels of kmp_stream_matcher, predicts each
// response from accepted requests and compares it field by field.
// Depends on kmpm_pkg for the request and response types.
`timescale 1ns / 1ps

module kmp_stream_matcher_chk (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_stall,
   input  wire kmpm_pkg::req_type req_data,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_stall,
   input  wire kmpm_pkg::rsp_type rsp_data,
   output int                     fail_count,
   output int                     pending,
   output int                     req_count,
   output int                     rsp_count,
   output int                     full_count,
   output int                     drop_count,
   output int                     empty_count,
   output int                     longest_match
);

   import kmpm_pkg::*;

   // Responses predicted but not yet seen, oldest first
   rsp_type match_results_q[$];

   // Predictor copy of the pattern, its failure links and the three prefix lengths
   logic [SYM_W-1:0] pat_bytes  [MAX_PATTERN];
   logic [LEN_W-1:0] fail_links [MAX_PATTERN];
   logic [LEN_W-1:0] pat_len;
   logic [LEN_W-1:0] build_len;
   logic [LEN_W-1:0] text_len;

   // Prefix length after byte c, starting from prefix length from (< pat_len)
   function automatic logic [LEN_W-1:0] walk_links(input logic [LEN_W-1:0] from,
                                                    input logic [SYM_W-1:0] c);
      logic [LEN_W-1:0] j;
      j = from;
      while (j != 0 && pat_bytes[j[ADDR_W-1:0]] != c)
         j = fail_links[ADDR_W'(j - LEN_W'(1))];
      if (pat_bytes[j[ADDR_W-1:0]] == c)
         j = j + LEN_W'(1);
      return j;
   endfunction

   // Applies one request to the predictor state and returns its response
   function automatic rsp_type kmp_next_result(input req_type r);
      rsp_type          res;
      logic [LEN_W-1:0] j;
      res = '0;
      case (r.opcode)
         OP_CLEAR: begin
            pat_len   = '0;
            build_len = '0;
            text_len  = '0;
         end
         OP_APPEND: begin
            if (pat_len >= MAX_PATTERN) begin
               res.status = ST_FULL;
            end else begin
               pat_bytes[pat_len[ADDR_W-1:0]] = r.symbol;
               if (pat_len == 0)
                  build_len = '0;
               else
                  build_len = walk_links(build_len, r.symbol);
               fail_links[pat_len[ADDR_W-1:0]] = build_len;
               pat_len = pat_len + LEN_W'(1);
            end
         end
         OP_TEXT: begin
            if (pat_len == 0) begin
               res.status = ST_EMPTY;
            end else begin
               j = walk_links(text_len, r.symbol);
               res.match_len = j;
               // whole pattern seen: fall back so overlapping matches are found
               if (j >= pat_len) begin
                  res.full_match = 1'b1;
                  text_len = fail_links[ADDR_W'(pat_len - LEN_W'(1))];
               end else begin
                  text_len = j;
               end
            end
         end
         default: begin
            text_len = '0;
         end
      endcase
      return res;
   endfunction

   // Predict on each accepted request, compare on each accepted response
   always @(posedge clock) begin : watch_proc
      rsp_type want;
      if (reset) begin
         pat_len   = '0;
         build_len = '0;
         text_len  = '0;
         match_results_q.delete();
      end else begin
         if (req_valid && !req_stall) begin
            match_results_q.push_back(kmp_next_result(req_data));
            req_count++;
         end
         if (rsp_valid && !rsp_stall) begin
            rsp_count++;
            if (match_results_q.size() == 0) begin
               $error("response with no request outstanding: match_len %0d",
                      rsp_data.match_len);
               fail_count++;
            end else begin
               want = match_results_q.pop_front();
               if (rsp_data.match_len !== want.match_len) begin
                  $error("match_len: expected %0d, got %0d", want.match_len,
                         rsp_data.match_len);
                  fail_count++;
               end
               if (rsp_data.full_match !== want.full_match) begin
                  $error("full_match: expected %0d, got %0d", want.full_match,
                         rsp_data.full_match);
                  fail_count++;
               end
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_data.status);
                  fail_count++;
               end
               // run statistics for the summary
               if (want.full_match)
                  full_count++;
               if (want.status == ST_FULL)
                  drop_count++;
               if (want.status == ST_EMPTY)
                  empty_count++;
               if (want.match_len > longest_match)
                  longest_match = int'(want.match_len);
            end
         end
      end
      pending = match_results_q.size();
   end

endmodule

// ===== tb/kmp_stream_matcher_tb.sv =====
// kmp_stream_matcher_tb: stimulus and verdict for kmp_stream_matcher; directed cases,
// then random pattern/text episodes under varying idle on both channels.
// Depends on kmpm_pkg, kmp_stream_matcher and kmp_stream_matcher_chk.
`timescale 1ns / 1ps

module kmp_stream_matcher_tb;
   import kmpm_pkg::*;

   localparam int STALL_LIMIT  = 4000;   // cycles with no handshake on either channel
   localparam int HOLD_CYCLES  = 150;    // long receiver hold-off
   localparam int DRAIN_CYCLES = 40;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   int src_idle_pct;
   int dst_idle_pct;
   bit hold_req;
   int sent_count;
   int quiet_cycles;

   int fail_count;
   int pending;
   int req_count;
   int rsp_count;
   int full_count;
   int drop_count;
   int empty_count;
   int longest_match;

   kmp_stream_matcher u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   kmp_stream_matcher_chk u_chk (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .pending       (pending),
      .req_count     (req_count),
      .rsp_count     (rsp_count),
      .full_count    (full_count),
      .drop_count    (drop_count),
      .empty_count   (empty_count),
      .longest_match (longest_match)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Watchdog: ends the run when neither channel moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("kmp_stream_matcher_tb: no handshake for %0d cycles", STALL_LIMIT);
            $display("kmp_stream_matcher_tb: done, errors");
            $finish;
         end
      end
   end

   // Response side: random stall, plus one long hold-off when asked
   initial begin : rsp_side
      bit hold_done;
      hold_done = 1'b0;
      rsp_stall = 1'b0;
      @(posedge clock);
      while (reset)
         @(posedge clock);
      forever begin
         if (hold_req && !hold_done) begin
            repeat (HOLD_CYCLES) begin
               rsp_stall <= 1'b1;
               @(posedge clock);
            end
            hold_done = 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < dst_idle_pct);
            @(posedge clock);
         end
      end
   end

   // One request, with random idle ahead of it; returns once accepted
   task automatic send_req(input opcode_type op, input logic [SYM_W-1:0] sym);
      while ($urandom_range(99) < src_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{opcode: op, symbol: sym};
      do
         @(posedge clock);
      while (req_stall);
      sent_count++;
   endtask

   // Short pattern over a small alphabet, then text over the same alphabet
   // with restarts, late appends, clears and stray bytes mixed in
   task automatic short_episode();
      logic [SYM_W-1:0] base;
      int               spread;
      int               plen;
      int               roll;
      base   = SYM_W'($urandom_range(0, 255));
      spread = ($urandom_range(3) == 0) ? 3 : 1;
      plen   = ($urandom_range(9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 5);
      send_req(OP_CLEAR, SYM_W'($urandom_range(0, 255)));
      repeat (plen)
         send_req(OP_APPEND, base ^ SYM_W'($urandom_range(0, spread)));
      repeat ($urandom_range(8, 40)) begin
         roll = $urandom_range(99);
         if (roll < 3) begin
            send_req(OP_RESTART, SYM_W'($urandom_range(0, 255)));
         end else if (roll < 5) begin
            send_req(OP_APPEND, base ^ SYM_W'($urandom_range(0, spread)));
         end else if (roll < 7) begin
            send_req(opcode_type'($urandom_range(3)), SYM_W'($urandom_range(0, 255)));
         end else if (roll < 8) begin
            send_req(OP_CLEAR, SYM_W'($urandom_range(0, 255)));
            send_req(OP_TEXT, SYM_W'($urandom_range(0, 255)));
            send_req(OP_APPEND, base ^ SYM_W'($urandom_range(0, spread)));
         end else begin
            send_req(OP_TEXT, base ^ SYM_W'($urandom_range(0, spread)));
         end
      end
   endtask

   // Fill the store with a periodic pattern, overflow it, then stream the same
   // period as text so whole-store matches occur
   task automatic long_episode();
      logic [SYM_W-1:0] syms [4];
      int               period;
      period = $urandom_range(1, 4);
      foreach (syms[i])
         syms[i] = SYM_W'($urandom_range(0, 255));
      send_req(OP_CLEAR, SYM_W'($urandom_range(0, 255)));
      for (int i = 0; i < MAX_PATTERN; i++)
         send_req(OP_APPEND, syms[2'(i % period)]);
      repeat ($urandom_range(1, 3))
         send_req(OP_APPEND, SYM_W'($urandom_range(0, 255)));
      for (int i = 0; i < $urandom_range(270, 300); i++) begin
         if ($urandom_range(99) == 0)
            send_req(OP_TEXT, SYM_W'($urandom_range(0, 255)));
         else
            send_req(OP_TEXT, syms[2'(i % period)]);
      end
   endtask

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      src_idle_pct = 0;
      dst_idle_pct = 0;
      hold_req     = 1'b0;
      sent_count   = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: text before any pattern, extreme bytes, overlapping matches
      send_req(OP_TEXT,    8'hFF);
      send_req(OP_APPEND,  8'h00);
      send_req(OP_APPEND,  8'hFF);
      send_req(OP_APPEND,  8'h00);
      send_req(OP_TEXT,    8'h00);
      send_req(OP_TEXT,    8'hFF);
      send_req(OP_TEXT,    8'h00);
      send_req(OP_TEXT,    8'hFF);
      send_req(OP_TEXT,    8'h00);
      send_req(OP_TEXT,    8'h55);
      // restart, then append while a text prefix is live
      send_req(OP_TEXT,    8'h00);
      send_req(OP_RESTART, 8'hFF);
      send_req(OP_TEXT,    8'hFF);
      send_req(OP_TEXT,    8'h00);
      send_req(OP_APPEND,  8'hFF);
      send_req(OP_TEXT,    8'hFF);
      send_req(OP_TEXT,    8'h00);
      send_req(OP_TEXT,    8'hFF);
      // clear, text on the empty pattern, single-byte pattern
      send_req(OP_CLEAR,   8'hAA);
      send_req(OP_TEXT,    8'hAA);
      send_req(OP_APPEND,  8'hA5);
      send_req(OP_TEXT,    8'hA5);
      send_req(OP_TEXT,    8'hA5);
      send_req(OP_TEXT,    8'h5A);

      // random, sender idles less than receiver; long hold-off early on
      src_idle_pct = 29;
      dst_idle_pct = 58;
      hold_req     = 1'b1;
      while (sent_count < 600)
         short_episode();

      // random, roles swapped; includes one full-store episode
      src_idle_pct = 58;
      dst_idle_pct = 29;
      long_episode();
      while (sent_count < 1200)
         short_episode();

      // random, back to back
      src_idle_pct = 0;
      dst_idle_pct = 0;
      while (sent_count < 1720)
         short_episode();

      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("kmp_stream_matcher_tb: %0d requests, %0d responses, %0d full matches",
               req_count, rsp_count, full_count);
      $display("kmp_stream_matcher_tb: %0d dropped appends, %0d empty-pattern texts, longest %0d",
               drop_count, empty_count, longest_match);
      if (fail_count == 0 && pending == 0) begin
         $display("kmp_stream_matcher_tb: done, clean");
      end else begin
         $display("kmp_stream_matcher_tb: done, errors");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
src/kmpm_pkg.sv
src/kmpm_ram.sv
src/kmp_stream_matcher.sv
tb/kmp_stream_matcher_chk.sv
tb/kmp_stream_matcher_tb.sv
